// ===== hdl/srcc_pkg.sv =====
// shared constants, types and crc function for the settings record crc checker
package srcc_pkg;

  localparam int RECORD_BYTES = 38;
  localparam int POS_W        = 6;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);

  localparam logic [7:0]  CRC_POLY      = 8'h07;
  localparam logic [15:0] MAGIC_RESET   = 16'h4553;
  localparam logic [7:0]  VERSION_RESET = 8'd4;

  localparam logic [1:0] VERDICT_OK  = 2'd0;
  localparam logic [1:0] VERDICT_HDR = 2'd1;
  localparam logic [1:0] VERDICT_CRC = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'd1;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       record_done;
    logic [1:0] verdict;
    logic [7:0] computed_crc;
  } result_t;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/srcc_if.sv =====
// request channel interfaces: record bytes in, results out, register writes
interface srcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
  modport mon    (input valid, input data_byte, input first_byte, input ready);
endinterface

interface srcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       record_done;
  logic [1:0] verdict;
  logic [7:0] computed_crc;
  modport source (output valid, output data_out, output record_done, output verdict,
                  output computed_crc, input ready);
  modport sink   (input valid, input data_out, input record_done, input verdict,
                  input computed_crc, output ready);
  modport mon    (input valid, input data_out, input record_done, input verdict,
                  input computed_crc, input ready);
endinterface

interface srcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [srcc_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
  modport mon    (input valid, input index, input wdata, input ready);
endinterface

// ===== hdl/srcc_cfg_regs.sv =====
// configuration registers: expected magic word and version
module srcc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  srcc_cfg_if.sink          cfg_ch,
  output srcc_pkg::cfg_t    cfg
);

  logic [15:0] magic_r, magic_nxt;
  logic [7:0]  version_r, version_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        srcc_pkg::CFG_MAGIC:   magic_nxt   = cfg_ch.wdata;
        srcc_pkg::CFG_VERSION: version_nxt = cfg_ch.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= srcc_pkg::MAGIC_RESET;
      version_r <= srcc_pkg::VERSION_RESET;
    end else begin
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
    end
  end

  assign cfg.magic   = magic_r;
  assign cfg.version = version_r;

endmodule

// ===== hdl/srcc_core.sv =====
// record state, header check and crc update for one byte per cycle while advance is high
module srcc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  srcc_pkg::cfg_t      cfg,
  output srcc_pkg::result_t   res
);

  logic [srcc_pkg::POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0] crc_r, crc_nxt, crc_eff;
  logic [7:0] magic_lo_r, magic_lo_nxt;
  logic       hdr_bad_r, hdr_bad_nxt, hdr_eff;

  // first-byte flag abandons any partial record
  assign pos_eff = first_byte ? '0 : pos_r;
  assign crc_eff = first_byte ? 8'd0 : crc_r;
  assign hdr_eff = first_byte ? 1'b0 : hdr_bad_r;

  always_comb begin
    pos_nxt          = pos_r;
    crc_nxt          = crc_r;
    magic_lo_nxt     = magic_lo_r;
    hdr_bad_nxt      = hdr_bad_r;
    res.data_out     = data_byte;
    res.record_done  = 1'b0;
    res.verdict      = srcc_pkg::VERDICT_OK;
    res.computed_crc = 8'd0;
    if (pos_eff >= srcc_pkg::LAST_POS) begin
      res.record_done  = 1'b1;
      res.computed_crc = crc_eff;
      if (hdr_eff) begin
        res.verdict = srcc_pkg::VERDICT_HDR;
      end else if (crc_eff != data_byte) begin
        res.verdict = srcc_pkg::VERDICT_CRC;
      end
      pos_nxt     = '0;
      crc_nxt     = 8'd0;
      hdr_bad_nxt = 1'b0;
    end else begin
      hdr_bad_nxt = hdr_eff;
      if (pos_eff == srcc_pkg::POS_W'(0)) begin
        magic_lo_nxt = data_byte;
        hdr_bad_nxt  = 1'b0;
      end else if (pos_eff == srcc_pkg::POS_W'(1)) begin
        if ({data_byte, magic_lo_r} != cfg.magic) hdr_bad_nxt = 1'b1;
      end else if (pos_eff == srcc_pkg::POS_W'(2)) begin
        if (data_byte != cfg.version) hdr_bad_nxt = 1'b1;
      end
      // byte 0 always starts from a zero crc
      crc_nxt = srcc_pkg::crc8_update((pos_eff == '0) ? 8'd0 : crc_eff, data_byte);
      res.computed_crc = crc_nxt;
      pos_nxt = pos_eff + srcc_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= 8'd0;
      magic_lo_r <= 8'd0;
      hdr_bad_r  <= 1'b0;
    end else if (advance) begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      magic_lo_r <= magic_lo_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
    end
  end

endmodule

// ===== hdl/settings_record_crc_checker.sv =====
// top level: input register, record check logic, result register
//
//  channel | direction | payload                                   | handshake
//  in_ch   | in        | data_byte[7:0], first_byte                | valid/ready
//  out_ch  | out       | data_out, record_done, verdict, crc       | valid/ready
//  cfg_ch  | in        | index (0 magic, 1 version), wdata[15:0]   | valid/ready
//
// one byte per cycle sustained while out_ch is ready; an accepted byte is held in
// the input register, and its result then passes into the result register, from
// which out_ch presents it; the crc/header update between the two registers is
// combinational.
// synchronous active-low reset empties both stages, clears the record state and loads the register defaults.
// a stalled result holds the result register; the input register still takes
// one more byte, after which in_ch.ready drops until the result is taken.
module settings_record_crc_checker (
  input logic        clk,
  input logic        rst_n,
  srcc_in_if.sink    in_ch,
  srcc_out_if.source out_ch,
  srcc_cfg_if.sink   cfg_ch
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  logic       out_valid_r, out_valid_nxt;
  logic       advance, in_accept;

  srcc_pkg::cfg_t    cfg;
  srcc_pkg::result_t res;
  srcc_pkg::result_t res_r;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_first_r <= in_ch.first_byte;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  srcc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  srcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .cfg        (cfg),
    .res        (res)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_out     = res_r.data_out;
  assign out_ch.record_done  = res_r.record_done;
  assign out_ch.verdict      = res_r.verdict;
  assign out_ch.computed_crc = res_r.computed_crc;

endmodule

// ===== hdl/srcc_checker.sv =====
// port-level assertions for the settings record crc checker, with bind
module srcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_done,
  input logic [1:0] out_verdict,
  input logic [7:0] out_crc,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // reset empties the result stage
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a verdict only ever rides on the last byte of a record, and uses a known code
  a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done ?
      (out_verdict == srcc_pkg::VERDICT_OK || out_verdict == srcc_pkg::VERDICT_HDR ||
       out_verdict == srcc_pkg::VERDICT_CRC) :
      (out_verdict == srcc_pkg::VERDICT_OK)))
    else $error("bad verdict on result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_data) && $stable(out_done) &&
       $stable(out_verdict) && $stable(out_crc)))
    else $error("stalled result changed");

  // input side is open whenever the result side takes requests
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while result side ready");

  // register writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind settings_record_crc_checker srcc_checker u_srcc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_data    (out_ch.data_out),
  .out_done    (out_ch.record_done),
  .out_verdict (out_ch.verdict),
  .out_crc     (out_ch.computed_crc),
  .cfg_valid   (cfg_ch.valid),
  .cfg_ready   (cfg_ch.ready)
);
